FILE: src/xoshiro_pkg.sv
// ============================================================================
// xoshiro_pkg
// Shared command codes, datapath operation codes, constants and types of the
// xoshiro256** generator.
// ============================================================================
package xoshiro_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned WORD_W = 64;

  localparam logic [CMD_W-1:0] CMD_NEXT      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEED64    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEED256   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_JUMP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LONG_JUMP = 3'd4;

  localparam logic [3:0] OP_IDLE      = 4'd0;
  localparam logic [3:0] OP_NEXT      = 4'd1;
  localparam logic [3:0] OP_LOAD4     = 4'd2;
  localparam logic [3:0] OP_CTR_LOAD  = 4'd3;
  localparam logic [3:0] OP_MIX_INIT  = 4'd4;
  localparam logic [3:0] OP_MUL       = 4'd5;
  localparam logic [3:0] OP_MIX_MID   = 4'd6;
  localparam logic [3:0] OP_MIX_STORE = 4'd7;
  localparam logic [3:0] OP_LEAP_CLR  = 4'd8;
  localparam logic [3:0] OP_LEAP_STEP = 4'd9;
  localparam logic [3:0] OP_LEAP_END  = 4'd10;

  localparam logic [1:0] MUL_LAST  = 2'd3;
  localparam logic [1:0] WORD_LAST = 2'd3;
  localparam logic [7:0] LEAP_LAST = 8'hff;

  localparam logic [WORD_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_C2     = 64'h94d049bb133111eb;
  localparam int unsigned       STATE_ROT  = 45;

  localparam logic [4*WORD_W-1:0] JUMP_MASK = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };
  localparam logic [4*WORD_W-1:0] LONG_JUMP_MASK = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
  };

  typedef logic [3:0][WORD_W-1:0] xo_state_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] word;
    logic [1:0] phase;
    logic       csel;
    logic       leap_long;
    logic [7:0] leap_idx;
    logic       load_out;
    logic       status;
  } xo_cmd_t;

  function automatic logic leap_mask_bit(input logic long_jump, input logic [7:0] idx);
    logic [4*WORD_W-1:0] m;
    m = long_jump ? LONG_JUMP_MASK : JUMP_MASK;
    return m[idx];
  endfunction

endpackage

FILE: src/xoshiro_dp.sv
// ============================================================================
// xoshiro_dp
// Datapath: generator state, output scrambler, splitmix seeding unit with a
// shared 32x32 multiplier, jump accumulator and the result register.
// ============================================================================
module xoshiro_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xoshiro_pkg::xo_cmd_t cmd,
  input  logic [63:0]          seed_a,
  input  logic [63:0]          seed_b,
  input  logic [63:0]          seed_c,
  input  logic [63:0]          seed_d,
  output logic                 seed_zero,
  output logic [63:0]          out_value,
  output logic                 out_status
);

  xoshiro_pkg::xo_state_t st_r, st_nxt, adv, jacc_r, jacc_nxt;
  logic [63:0] ctr_r, ctr_nxt, x_r, x_nxt, acc_r, acc_nxt, prod_r, prod_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic        out_status_r, out_status_nxt;
  logic [63:0] s1_x5, s1_rot, scram;
  logic [63:0] s2a, s3a, s1a, s0a, s3r;
  logic [63:0] ctr_sum, mix_x, coef, mul_p, pp;
  logic [31:0] mul_a, mul_b;

  assign seed_zero = ~|{seed_a, seed_b, seed_c, seed_d};

  always_comb begin
    s2a    = st_r[2] ^ st_r[0];
    s3a    = st_r[3] ^ st_r[1];
    s1a    = st_r[1] ^ s2a;
    s0a    = st_r[0] ^ s3a;
    s3r    = (s3a << xoshiro_pkg::STATE_ROT) | (s3a >> (64 - xoshiro_pkg::STATE_ROT));
    adv[0] = s0a;
    adv[1] = s1a;
    adv[2] = s2a ^ (st_r[1] << 17);
    adv[3] = s3r;
    s1_x5  = st_r[1] + (st_r[1] << 2);
    s1_rot = (s1_x5 << 7) | (s1_x5 >> 57);
    scram  = s1_rot + (s1_rot << 3);
  end

  assign ctr_sum = ctr_r + xoshiro_pkg::MIX_GOLDEN;
  assign mix_x   = ctr_sum ^ (ctr_sum >> 30);
  assign coef    = cmd.csel ? xoshiro_pkg::MIX_C2 : xoshiro_pkg::MIX_C1;
  assign mul_a   = (cmd.phase == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign mul_b   = (cmd.phase == 2'd1) ? coef[63:32] : coef[31:0];
  assign mul_p   = {32'b0, mul_a} * {32'b0, mul_b};
  assign pp      = (cmd.phase == 2'd0) ? mul_p : {mul_p[31:0], 32'b0};

  always_comb begin
    st_nxt         = st_r;
    jacc_nxt       = jacc_r;
    ctr_nxt        = ctr_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    case (cmd.op)
      xoshiro_pkg::OP_NEXT: begin
        st_nxt = adv;
      end
      xoshiro_pkg::OP_LOAD4: begin
        st_nxt = {seed_d, seed_c, seed_b, seed_a};
      end
      xoshiro_pkg::OP_CTR_LOAD: begin
        ctr_nxt = seed_a;
      end
      xoshiro_pkg::OP_MIX_INIT: begin
        ctr_nxt = ctr_sum;
        x_nxt   = mix_x;
        acc_nxt = '0;
      end
      xoshiro_pkg::OP_MUL: begin
        if (cmd.phase != xoshiro_pkg::MUL_LAST) begin
          prod_nxt = pp;
        end
        if (cmd.phase != 2'd0) begin
          acc_nxt = acc_r + prod_r;
        end
      end
      xoshiro_pkg::OP_MIX_MID: begin
        x_nxt   = acc_r ^ (acc_r >> 27);
        acc_nxt = '0;
      end
      xoshiro_pkg::OP_MIX_STORE: begin
        st_nxt[cmd.word] = acc_r ^ (acc_r >> 31);
      end
      xoshiro_pkg::OP_LEAP_CLR: begin
        jacc_nxt = '0;
      end
      xoshiro_pkg::OP_LEAP_STEP: begin
        if (xoshiro_pkg::leap_mask_bit(cmd.leap_long, cmd.leap_idx)) begin
          jacc_nxt = jacc_r ^ st_r;
        end
        st_nxt = adv;
      end
      xoshiro_pkg::OP_LEAP_END: begin
        st_nxt = jacc_r;
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_value_nxt  = (cmd.op == xoshiro_pkg::OP_NEXT) ? scram : 64'd0;
      out_status_nxt = cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jacc_r       <= jacc_nxt;
    ctr_r        <= ctr_nxt;
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

FILE: src/xoshiro_ctrl.sv
// ============================================================================
// xoshiro_ctrl
// Controller: accepts commands, sequences seeding and jumps, and owns the
// handshake of both channels.
// ============================================================================
module xoshiro_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic [2:0]           in_cmd,
  input  logic                 seed_zero,
  input  logic                 out_tready,
  output logic                 in_tready,
  output logic                 out_tvalid,
  output xoshiro_pkg::xo_cmd_t dp_cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MIX_INIT  = 3'd1;
  localparam logic [2:0] ST_MIX_MUL1  = 3'd2;
  localparam logic [2:0] ST_MIX_MID   = 3'd3;
  localparam logic [2:0] ST_MIX_MUL2  = 3'd4;
  localparam logic [2:0] ST_MIX_STORE = 3'd5;
  localparam logic [2:0] ST_LEAP      = 3'd6;
  localparam logic [2:0] ST_LEAP_END  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] word_r, word_nxt, phase_r, phase_nxt;
  logic [7:0] step_r, step_nxt;
  logic       long_r, long_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt        = state_r;
    word_nxt         = word_r;
    phase_nxt        = phase_r;
    step_nxt         = step_r;
    long_nxt         = long_r;
    dp_cmd.op        = xoshiro_pkg::OP_IDLE;
    dp_cmd.word      = word_r;
    dp_cmd.phase     = phase_r;
    dp_cmd.csel      = 1'b0;
    dp_cmd.leap_long = long_r;
    dp_cmd.leap_idx  = step_r;
    dp_cmd.load_out  = 1'b0;
    dp_cmd.status    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            xoshiro_pkg::CMD_NEXT: begin
              dp_cmd.op       = xoshiro_pkg::OP_NEXT;
              dp_cmd.load_out = 1'b1;
            end
            xoshiro_pkg::CMD_SEED64: begin
              dp_cmd.op = xoshiro_pkg::OP_CTR_LOAD;
              word_nxt  = 2'd0;
              state_nxt = ST_MIX_INIT;
            end
            xoshiro_pkg::CMD_SEED256: begin
              dp_cmd.op       = seed_zero ? xoshiro_pkg::OP_IDLE : xoshiro_pkg::OP_LOAD4;
              dp_cmd.load_out = 1'b1;
              dp_cmd.status   = seed_zero;
            end
            xoshiro_pkg::CMD_JUMP, xoshiro_pkg::CMD_LONG_JUMP: begin
              dp_cmd.op = xoshiro_pkg::OP_LEAP_CLR;
              long_nxt  = (in_cmd == xoshiro_pkg::CMD_LONG_JUMP);
              step_nxt  = 8'd0;
              state_nxt = ST_LEAP;
            end
            default: begin
              dp_cmd.load_out = 1'b1;
            end
          endcase
        end
      end
      ST_MIX_INIT: begin
        dp_cmd.op = xoshiro_pkg::OP_MIX_INIT;
        phase_nxt = 2'd0;
        state_nxt = ST_MIX_MUL1;
      end
      ST_MIX_MUL1: begin
        dp_cmd.op = xoshiro_pkg::OP_MUL;
        phase_nxt = phase_r + 2'd1;
        if (phase_r == xoshiro_pkg::MUL_LAST) begin
          state_nxt = ST_MIX_MID;
        end
      end
      ST_MIX_MID: begin
        dp_cmd.op = xoshiro_pkg::OP_MIX_MID;
        phase_nxt = 2'd0;
        state_nxt = ST_MIX_MUL2;
      end
      ST_MIX_MUL2: begin
        dp_cmd.op   = xoshiro_pkg::OP_MUL;
        dp_cmd.csel = 1'b1;
        phase_nxt   = phase_r + 2'd1;
        if (phase_r == xoshiro_pkg::MUL_LAST) begin
          state_nxt = ST_MIX_STORE;
        end
      end
      ST_MIX_STORE: begin
        dp_cmd.op = xoshiro_pkg::OP_MIX_STORE;
        if (word_r == xoshiro_pkg::WORD_LAST) begin
          dp_cmd.load_out = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          word_nxt  = word_r + 2'd1;
          state_nxt = ST_MIX_INIT;
        end
      end
      ST_LEAP: begin
        dp_cmd.op = xoshiro_pkg::OP_LEAP_STEP;
        step_nxt  = step_r + 8'd1;
        if (step_r == xoshiro_pkg::LEAP_LAST) begin
          state_nxt = ST_LEAP_END;
        end
      end
      ST_LEAP_END: begin
        dp_cmd.op       = xoshiro_pkg::OP_LEAP_END;
        dp_cmd.load_out = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = dp_cmd.load_out || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      word_r      <= 2'd0;
      phase_r     <= 2'd0;
      step_r      <= 8'd0;
      long_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      long_r      <= long_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_busy_done_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEAP_END || (state_r == ST_MIX_STORE && word_r == xoshiro_pkg::WORD_LAST))
      |-> !out_valid_r)
    else $error("busy command finished while a result was still pending");

  a_jump_enters_leap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == xoshiro_pkg::CMD_JUMP || in_cmd == xoshiro_pkg::CMD_LONG_JUMP)
      |=> state_r == ST_LEAP && step_r == 8'd0)
    else $error("jump command did not start the leap sequence");

  a_next_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd == xoshiro_pkg::CMD_NEXT |=> out_valid_r && state_r == ST_IDLE)
    else $error("next command did not produce a result in the following cycle");

  a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX_STORE && word_r == xoshiro_pkg::WORD_LAST |=> out_valid_r && state_r == ST_IDLE)
    else $error("seeding did not end with a result");

endmodule

FILE: src/xoshiro256_star_star_prng_unit.sv
// ============================================================================
// xoshiro256_star_star_prng_unit
// xoshiro256** generator with one-word and four-word seeding and jump-ahead.
// ============================================================================
// Each transfer on the in_ channel carries a command and four seed words and
// yields exactly one transfer on the out_ channel, in order.
// Next: the scrambled value appears in the cycle after acceptance and the state
// advances; next commands stream at one per cycle, limited only by out_tready.
// Four-word seed: an all-zero seed returns status 1 and changes nothing.
// Unused command codes return zero with status 0.
// One-word seed: four splitmix64 rounds run on one shared 32x32 multiplier,
// each of a round's two multiplies summed from 32-bit partial products.
// Jump and long jump: one state step and one conditional accumulate per mask
// bit, 256 bits in all.
// The result register decouples the channels: a new command is accepted while
// a result waits, as long as that result is taken in the same cycle.
// Reset clears the state to zero; next then returns zero until seeded.
// ============================================================================
module xoshiro256_star_star_prng_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [263:0] in_tdata,   // cmd[2:0], seed_a, seed_b, seed_c, seed_d, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // random_value[63:0], status[64], zero pad
);

  xoshiro_pkg::xo_cmd_t dp_cmd;
  logic                 seed_zero;
  logic [63:0]          out_value;
  logic                 out_status;

  xoshiro_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tdata[2:0]),
    .seed_zero  (seed_zero),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .dp_cmd     (dp_cmd)
  );

  xoshiro_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .seed_a     (in_tdata[66:3]),
    .seed_b     (in_tdata[130:67]),
    .seed_c     (in_tdata[194:131]),
    .seed_d     (in_tdata[258:195]),
    .seed_zero  (seed_zero),
    .out_value  (out_value),
    .out_status (out_status)
  );

  assign out_tdata = {7'd0, out_status, out_value};

endmodule

FILE: test/tb_xoshiro256_star_star_prng_unit.sv
// ============================================================================
// tb_xoshiro256_star_star_prng_unit
// Self-checking testbench for the xoshiro256** generator unit.
// ============================================================================
// A short table of directed commands exercises the unseeded generator, the
// rejected all-zero seed, the unused command codes, seed extremes and both
// jumps. Random commands follow, mostly next with regular reseeding and rare
// jumps. A behavioral copy of the generator predicts each result not given by
// the table, and each transfer on the out_ channel is compared with the oldest
// expected result. Both channels idle at random outside a calm stretch, and
// the result side holds off once for a long stretch so that the input channel stalls.
// ============================================================================
module tb_xoshiro256_star_star_prng_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CMD_W  = xoshiro_pkg::CMD_W;
  localparam int unsigned WORD_W = xoshiro_pkg::WORD_W;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [WORD_W-1:0] WORD_ZERO = '0;
  localparam logic [WORD_W-1:0] WORD_ONES = '1;
  localparam logic [WORD_W-1:0] WORD_ALT  = 64'h5555555555555555;

  localparam logic [WORD_W-1:0] SM_INCREMENT = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] SM_MUL_A     = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] SM_MUL_B     = 64'h94d049bb133111eb;
  localparam int unsigned       STEP_ROTATE  = 45;

  localparam logic [255:0] SHORT_JUMP_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };
  localparam logic [255:0] LONG_JUMP_POLY = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
  };

  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_START   = 600;
  localparam int CALM_END     = 900;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              status;
  } prng_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic              typed;
    prng_result_t      res;
  } directed_row_t;

  localparam prng_result_t RESULT_OK       = '{value: '0, status: STATUS_OK};
  localparam prng_result_t RESULT_REJECTED = '{value: '0, status: STATUS_REJECT};

  localparam int DIRECTED_ROWS = 25;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_JUMP, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_LONG_JUMP, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_SEED256, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b1, RESULT_REJECTED},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b1, RESULT_OK},
    '{CMD_RSVD_LO, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 1'b1, RESULT_OK},
    '{CMD_RSVD_HI, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_SEED256, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_SEED256, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ONES, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_SEED256, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b1, RESULT_REJECTED},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_SEED64, WORD_ZERO, WORD_ALT, WORD_ALT, WORD_ALT, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_JUMP, WORD_ALT, WORD_ALT, WORD_ALT, WORD_ALT, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_LONG_JUMP, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_SEED64, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 1'b1, RESULT_OK},
    '{CMD_RSVD_MID, WORD_ALT, WORD_ZERO, WORD_ONES, WORD_ALT, 1'b1, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0, RESULT_OK},
    '{xoshiro_pkg::CMD_NEXT, WORD_ONES, WORD_ALT, WORD_ONES, WORD_ALT, 1'b0, RESULT_OK}
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [263:0] in_tdata;   // cmd[2:0], seed_a, seed_b, seed_c, seed_d, zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;  // random_value[63:0], status[64], zero pad

  logic [3:0][WORD_W-1:0] gen_state;
  prng_result_t           expected_results[$];
  int                     error_count;
  int                     results_checked;
  int                     random_issued;
  int                     rejected_seeds;
  int                     cmd_seen [8];
  bit                     calm_phase;

  xoshiro256_star_star_prng_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                               input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  function automatic logic [WORD_W-1:0] splitmix_word(input logic [WORD_W-1:0] seed,
                                                      input int unsigned n);
    logic [WORD_W-1:0] z;
    z = seed + SM_INCREMENT * WORD_W'(n);
    z = (z ^ (z >> 30)) * SM_MUL_A;
    z = (z ^ (z >> 27)) * SM_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [WORD_W-1:0] step_generator();
    logic [WORD_W-1:0] scrambled;
    logic [WORD_W-1:0] shifted;
    scrambled = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
    shifted = gen_state[1] << 17;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= shifted;
    gen_state[3] = rotl64(gen_state[3], STEP_ROTATE);
    return scrambled;
  endfunction

  function automatic void leap_generator(input logic [255:0] poly);
    logic [3:0][WORD_W-1:0] acc;
    logic [WORD_W-1:0]      discard;
    acc = '0;
    for (int i = 0; i < 256; i++) begin
      if (poly[i]) acc ^= gen_state;
      discard = step_generator();
    end
    gen_state = acc;
  endfunction

  function automatic prng_result_t predict_result(input logic [CMD_W-1:0] cmd,
                                                  input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c,
                                                  input logic [WORD_W-1:0] d);
    prng_result_t r;
    r = RESULT_OK;
    case (cmd)
      xoshiro_pkg::CMD_NEXT: r.value = step_generator();
      xoshiro_pkg::CMD_SEED64: begin
        for (int n = 1; n <= 4; n++) gen_state[n-1] = splitmix_word(a, n);
      end
      xoshiro_pkg::CMD_SEED256: begin
        if ((a | b | c | d) == WORD_ZERO) r.status = STATUS_REJECT;
        else gen_state = {d, c, b, a};
      end
      xoshiro_pkg::CMD_JUMP: leap_generator(SHORT_JUMP_POLY);
      xoshiro_pkg::CMD_LONG_JUMP: leap_generator(LONG_JUMP_POLY);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return WORD_ZERO;
    if (r == 1) return WORD_ONES;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 74) return xoshiro_pkg::CMD_NEXT;
    if (r < 82) return xoshiro_pkg::CMD_SEED64;
    if (r < 90) return xoshiro_pkg::CMD_SEED256;
    if (r < 92) return xoshiro_pkg::CMD_JUMP;
    if (r < 94) return xoshiro_pkg::CMD_LONG_JUMP;
    return CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] a,
                              input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
                              input logic [WORD_W-1:0] d, input logic typed,
                              input prng_result_t typed_res);
    prng_result_t predicted;
    while (!calm_phase && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, d, c, b, a, cmd};
    do @(posedge clk); while (!in_tready);
    predicted = predict_result(cmd, a, b, c, d);
    expected_results.push_back(typed ? typed_res : predicted);
    cmd_seen[cmd]++;
    if (cmd == xoshiro_pkg::CMD_SEED256 && predicted.status == STATUS_REJECT) rejected_seeds++;
  endtask

  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && random_issued >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm_phase || ($urandom_range(99) >= 25);
      end
    end
  end

  always @(posedge clk) begin : result_check
    prng_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: random_value %h status %b",
               out_tdata[63:0], out_tdata[64]);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[63:0] !== want.value) begin
          $error("random_value mismatch: expected %h, got %h", want.value, out_tdata[63:0]);
          error_count++;
        end
        if (out_tdata[64] !== want.status) begin
          $error("status mismatch: expected %b, got %b", want.status, out_tdata[64]);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("xoshiro256_star_star_prng_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] a, b, c, d;
    error_count     = 0;
    results_checked = 0;
    random_issued   = 0;
    rejected_seeds  = 0;
    calm_phase      = 1'b0;
    gen_state       = '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].c, directed_rows[i].d, directed_rows[i].typed,
                   directed_rows[i].res);
    end

    while (random_issued < RANDOM_ITEMS) begin
      calm_phase = (random_issued >= CALM_START && random_issued < CALM_END);
      cmd = pick_command();
      a = pick_word();
      b = pick_word();
      c = pick_word();
      d = pick_word();
      if (cmd == xoshiro_pkg::CMD_SEED256 && $urandom_range(99) < 15) begin
        a = WORD_ZERO;
        b = WORD_ZERO;
        c = WORD_ZERO;
        d = WORD_ZERO;
      end
      send_command(cmd, a, b, c, d, 1'b0, RESULT_OK);
      if (cmd <= xoshiro_pkg::CMD_LONG_JUMP) random_issued++;
    end
    calm_phase = 1'b0;
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d next, %0d one-word seeds, %0d four-word seeds",
             results_checked, cmd_seen[xoshiro_pkg::CMD_NEXT],
             cmd_seen[xoshiro_pkg::CMD_SEED64], cmd_seen[xoshiro_pkg::CMD_SEED256]);
    $display("(%0d rejected), %0d jumps, %0d long jumps, %0d unused codes, one long hold-off",
             rejected_seeds, cmd_seen[xoshiro_pkg::CMD_JUMP],
             cmd_seen[xoshiro_pkg::CMD_LONG_JUMP],
             cmd_seen[CMD_RSVD_LO] + cmd_seen[CMD_RSVD_MID] + cmd_seen[CMD_RSVD_HI]);
    if (error_count == 0) begin
      $display("xoshiro256_star_star_prng_unit verification clean");
    end else begin
      $display("xoshiro256_star_star_prng_unit verification failed");
    end
    $finish;
  end

endmodule
